// File: rtl/lphs_pkg.sv
// Shared types, constants and codes of the linear probing hash set.
package lphs_pkg;

  localparam int CAPACITY      = 1024;
  localparam int MAX_KEY_BYTES = 8;
  localparam int SLOT_W        = $clog2(CAPACITY);
  localparam int SIZE_W        = 11;
  localparam int KEY_W         = 64;
  localparam int LEN_W         = 4;
  localparam int COUNT_W       = 11;
  // Largest hash sum is 255 * (1 + 2 + ... + 8) = 9180.
  localparam int SUM_MAX       = 255 * MAX_KEY_BYTES * (MAX_KEY_BYTES + 1) / 2;
  localparam int SUM_W         = $clog2(SUM_MAX + 1);
  localparam int BIT_W         = $clog2(SUM_W);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(CAPACITY);

  localparam logic [APB_AW-1:0] ADDR_TABLE_SIZE = APB_AW'(0);

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_REFUSED = 2'd1;
  localparam logic [1:0] STATUS_NO_SLOT = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [LEN_W-1:0]  len;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] home;
  } req_t;

  typedef struct packed {
    logic             used;
    logic             removed;
    logic [LEN_W-1:0] len;
    logic [KEY_W-1:0] key;
  } slot_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_MOD,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_CHECK
  } back_state_e;

endpackage

// File: rtl/lphs_front.sv
// Front end: takes a request, cleans the key, hashes it and reduces it to a home slot.
module lphs_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [1:0]                   mode_i,
  input  logic [lphs_pkg::KEY_W-1:0]   key_bytes_i,
  input  logic [lphs_pkg::LEN_W-1:0]   key_length_i,
  input  logic [lphs_pkg::SIZE_W-1:0]  size_i,
  input  logic                         full_i,
  output logic                         busy_o,
  output logic                         push_o,
  output lphs_pkg::req_t               req_o
);

  lphs_pkg::front_state_e state_q, state_d;
  logic [1:0]                  mode_q, mode_d;
  logic [lphs_pkg::LEN_W-1:0]  len_q, len_d;
  logic [lphs_pkg::KEY_W-1:0]  key_q, key_d;
  logic [lphs_pkg::KEY_W-1:0]  shift_q, shift_d;
  logic [lphs_pkg::LEN_W-1:0]  idx_q, idx_d;
  logic [lphs_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic [lphs_pkg::BIT_W-1:0]  bit_q, bit_d;

  logic [lphs_pkg::LEN_W-1:0]  len_clamp;
  logic [lphs_pkg::KEY_W-1:0]  key_clean;
  logic [lphs_pkg::SUM_W-1:0]  quot_part;
  logic [lphs_pkg::SUM_W+lphs_pkg::SIZE_W-1:0] size_shift;
  logic [lphs_pkg::LEN_W+7:0]  product;

  always_comb begin
    len_clamp = (key_length_i > lphs_pkg::LEN_W'(lphs_pkg::MAX_KEY_BYTES)) ?
                lphs_pkg::LEN_W'(lphs_pkg::MAX_KEY_BYTES) : key_length_i;
    for (int b = 0; b < lphs_pkg::MAX_KEY_BYTES; b++) begin
      key_clean[8*b +: 8] = (lphs_pkg::LEN_W'(b) < len_clamp) ? key_bytes_i[8*b +: 8] : 8'd0;
    end
    for (int b = lphs_pkg::MAX_KEY_BYTES; b < lphs_pkg::KEY_W / 8; b++) begin
      key_clean[8*b +: 8] = 8'd0;
    end
  end

  assign product    = shift_q[7:0] * (idx_q + lphs_pkg::LEN_W'(1));
  assign quot_part  = sum_q >> bit_q;
  assign size_shift = {{lphs_pkg::SUM_W{1'b0}}, size_i} << bit_q;

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    len_d   = len_q;
    key_d   = key_q;
    shift_d = shift_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    bit_d   = bit_q;
    push_o  = 1'b0;
    case (state_q)
      lphs_pkg::F_IDLE: begin
        if (accept_i) begin
          mode_d  = mode_i;
          len_d   = len_clamp;
          key_d   = key_clean;
          shift_d = key_clean;
          idx_d   = '0;
          sum_d   = '0;
          state_d = lphs_pkg::F_HASH;
        end
      end
      lphs_pkg::F_HASH: begin
        // Bytes past the length are already zero, so every byte position is summed.
        sum_d   = sum_q + lphs_pkg::SUM_W'(product);
        shift_d = shift_q >> 8;
        idx_d   = idx_q + lphs_pkg::LEN_W'(1);
        if (idx_q == lphs_pkg::LEN_W'(lphs_pkg::MAX_KEY_BYTES - 1)) begin
          bit_d   = lphs_pkg::BIT_W'(lphs_pkg::SUM_W - 1);
          state_d = lphs_pkg::F_MOD;
        end
      end
      lphs_pkg::F_MOD: begin
        // Restoring remainder, one quotient bit per cycle.
        if ({{lphs_pkg::SIZE_W{1'b0}}, quot_part} >=
            {{lphs_pkg::SUM_W{1'b0}}, size_i}) begin
          sum_d = sum_q - size_shift[lphs_pkg::SUM_W-1:0];
        end
        if (bit_q == '0) begin
          state_d = lphs_pkg::F_PUSH;
        end else begin
          bit_d = bit_q - lphs_pkg::BIT_W'(1);
        end
      end
      lphs_pkg::F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = lphs_pkg::F_IDLE;
        end
      end
      default: state_d = lphs_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lphs_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    len_q   <= len_d;
    key_q   <= key_d;
    shift_q <= shift_d;
    idx_q   <= idx_d;
    sum_q   <= sum_d;
    bit_q   <= bit_d;
  end

  assign busy_o     = (state_q != lphs_pkg::F_IDLE);
  assign req_o.mode = mode_q;
  assign req_o.len  = len_q;
  assign req_o.key  = key_q;
  assign req_o.home = sum_q[lphs_pkg::SLOT_W-1:0];

endmodule

// File: rtl/lphs_queue.sv
// Short request queue between the hashing front end and the probing back end.
module lphs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lphs_pkg::req_t req_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output lphs_pkg::req_t req_o
);

  lphs_pkg::req_t entry_q [lphs_pkg::QUEUE_DEPTH];
  logic [lphs_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [lphs_pkg::QPTR_W:0]   fill_q;

  assign full_o  = (fill_q == (lphs_pkg::QPTR_W+1)'(lphs_pkg::QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign req_o   = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == lphs_pkg::QPTR_W'(lphs_pkg::QUEUE_DEPTH - 1)) ?
                '0 : wr_q + lphs_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == lphs_pkg::QPTR_W'(lphs_pkg::QUEUE_DEPTH - 1)) ?
                '0 : rd_q + lphs_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + (lphs_pkg::QPTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - (lphs_pkg::QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= req_i;
    end
  end

endmodule

// File: rtl/lphs_back.sv
// Back end: owns the slot table, probes it one slot at a time and applies the request.
module lphs_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  lphs_pkg::req_t                req_i,
  output logic                          pop_o,
  input  logic [lphs_pkg::SIZE_W-1:0]   size_i,
  output logic                          clearing_o,
  output logic                          done_o,
  output logic                          was_present_o,
  output logic [1:0]                    status_o,
  output logic [lphs_pkg::COUNT_W-1:0]  live_count_o
);

  lphs_pkg::slot_t mem [lphs_pkg::CAPACITY];

  lphs_pkg::back_state_e state_q, state_d;
  lphs_pkg::req_t               req_q, req_d;
  logic [lphs_pkg::SLOT_W-1:0]  slot_q, slot_d;
  logic [lphs_pkg::SIZE_W-1:0]  cnt_q, cnt_d;
  logic [lphs_pkg::COUNT_W-1:0] count_q, count_d;
  logic [lphs_pkg::SLOT_W-1:0]  clr_q, clr_d;
  lphs_pkg::slot_t              rdata_q;
  logic                         done_q, done_d;
  logic                         present_q, present_d;
  logic [1:0]                   status_q, status_d;

  logic                         we;
  logic [lphs_pkg::SLOT_W-1:0]  waddr;
  lphs_pkg::slot_t              wdata;

  logic                         stop_hit;
  logic                         present;
  logic [lphs_pkg::SIZE_W-1:0]  cnt_next;
  logic [lphs_pkg::SIZE_W-1:0]  slot_inc;

  assign stop_hit = !rdata_q.used ||
                    (rdata_q.len == req_q.len && rdata_q.key == req_q.key);
  assign present  = stop_hit && rdata_q.used && !rdata_q.removed;
  assign cnt_next = cnt_q + lphs_pkg::SIZE_W'(1);
  assign slot_inc = {1'b0, slot_q} + lphs_pkg::SIZE_W'(1);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    slot_d    = slot_q;
    cnt_d     = cnt_q;
    count_d   = count_q;
    clr_d     = clr_q;
    done_d    = 1'b0;
    present_d = present_q;
    status_d  = status_q;
    pop_o     = 1'b0;
    we        = 1'b0;
    waddr     = slot_q;
    wdata     = '{used: 1'b1, removed: 1'b0, len: req_q.len, key: req_q.key};
    case (state_q)
      lphs_pkg::B_CLEAR: begin
        // Sweep the table after reset so every slot reads as never used.
        we     = 1'b1;
        waddr  = clr_q;
        wdata  = '0;
        clr_d  = clr_q + lphs_pkg::SLOT_W'(1);
        if (clr_q == lphs_pkg::SLOT_W'(lphs_pkg::CAPACITY - 1)) begin
          state_d = lphs_pkg::B_IDLE;
        end
      end
      lphs_pkg::B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          req_d   = req_i;
          slot_d  = req_i.home;
          cnt_d   = '0;
          state_d = lphs_pkg::B_READ;
        end
      end
      lphs_pkg::B_READ: begin
        state_d = lphs_pkg::B_CHECK;
      end
      lphs_pkg::B_CHECK: begin
        if (stop_hit || cnt_next == size_i) begin
          done_d    = 1'b1;
          present_d = present;
          status_d  = lphs_pkg::STATUS_DONE;
          state_d   = lphs_pkg::B_IDLE;
          if (req_q.mode == lphs_pkg::MODE_INSERT) begin
            if (count_q >= lphs_pkg::COUNT_W'(size_i >> 1)) begin
              status_d = lphs_pkg::STATUS_REFUSED;
            end else if (!stop_hit) begin
              status_d = lphs_pkg::STATUS_NO_SLOT;
            end else if (!present) begin
              we      = 1'b1;
              count_d = count_q + lphs_pkg::COUNT_W'(1);
            end
          end else if (req_q.mode == lphs_pkg::MODE_REMOVE) begin
            if (present) begin
              we            = 1'b1;
              wdata.removed = 1'b1;
              if (count_q != '0) begin
                count_d = count_q - lphs_pkg::COUNT_W'(1);
              end
            end
          end
        end else begin
          cnt_d   = cnt_next;
          slot_d  = (slot_inc == size_i) ? '0 : slot_inc[lphs_pkg::SLOT_W-1:0];
          state_d = lphs_pkg::B_READ;
        end
      end
      default: state_d = lphs_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lphs_pkg::B_CLEAR;
      count_q <= '0;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    slot_q    <= slot_d;
    cnt_q     <= cnt_d;
    present_q <= present_d;
    status_q  <= status_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[slot_q];
  end

  assign clearing_o    = (state_q == lphs_pkg::B_CLEAR);
  assign done_o        = done_q;
  assign was_present_o = present_q;
  assign status_o      = status_q;
  assign live_count_o  = count_q;

endmodule

// File: rtl/linear_probe_hash_set.sv
// Top level of the linear probing hash set: register port, front end, queue and back end.
//
//   channel   | handshake                    | payload
//   ----------+------------------------------+------------------------------------
//   request   | start, busy                  | mode_i, key_bytes_i, key_length_i
//   result    | done_o (one-cycle strobe)    | was_present_o, status_o, live_count_o
//   register  | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// The front end works through eight byte steps of the hash, then one remainder bit per cycle;
// it takes the next request as soon as its result is queued.
// The back end reads each probed slot through the table's registered read port, in B_READ
// and then B_CHECK, and probes from 1 to the table size slots per request.
// After reset the back end clears all 1024 slots of the table, one slot a cycle, and busy
// stays high meanwhile. The result strobe cannot be held off by the receiver.
module linear_probe_hash_set (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          mode_i,
  input  logic [lphs_pkg::KEY_W-1:0]          key_bytes_i,
  input  logic [lphs_pkg::LEN_W-1:0]          key_length_i,
  output logic                                done_o,
  output logic                                was_present_o,
  output logic [1:0]                          status_o,
  output logic [lphs_pkg::COUNT_W-1:0]        live_count_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lphs_pkg::APB_AW-1:0]         paddr,
  input  logic [lphs_pkg::APB_DW-1:0]         pwdata,
  output logic [lphs_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  logic [lphs_pkg::SIZE_W-1:0] size_q;
  logic [lphs_pkg::SIZE_W-1:0] size_act;
  logic                        front_busy;
  logic                        clearing;
  logic                        push;
  logic                        pop;
  logic                        full;
  logic                        empty;
  lphs_pkg::req_t              req_in;
  lphs_pkg::req_t              req_out;

  assign pready = 1'b1;
  assign prdata = (paddr == lphs_pkg::ADDR_TABLE_SIZE) ?
                  {{(lphs_pkg::APB_DW - lphs_pkg::SIZE_W){1'b0}}, size_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= lphs_pkg::SIZE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == lphs_pkg::ADDR_TABLE_SIZE) begin
      size_q <= pwdata[lphs_pkg::SIZE_W-1:0];
    end
  end

  always_comb begin
    size_act = size_q;
    if (size_q < lphs_pkg::SIZE_MIN) begin
      size_act = lphs_pkg::SIZE_MIN;
    end else if (size_q > lphs_pkg::SIZE_MAX) begin
      size_act = lphs_pkg::SIZE_MAX;
    end
  end

  assign busy = front_busy || clearing;

  lphs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (start && !busy),
    .mode_i       (mode_i),
    .key_bytes_i  (key_bytes_i),
    .key_length_i (key_length_i),
    .size_i       (size_act),
    .full_i       (full),
    .busy_o       (front_busy),
    .push_o       (push),
    .req_o        (req_in)
  );

  lphs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (req_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .req_o   (req_out)
  );

  lphs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .req_i         (req_out),
    .pop_o         (pop),
    .size_i        (size_act),
    .clearing_o    (clearing),
    .done_o        (done_o),
    .was_present_o (was_present_o),
    .status_o      (status_o),
    .live_count_o  (live_count_o)
  );

endmodule

// File: verif/linear_probe_hash_set_tb.sv
// Self-checking testbench for the linear probing hash set: lookups, inserts and removes.
`timescale 1ns / 100ps

module linear_probe_hash_set_tb;
  import lphs_pkg::*;

  localparam logic [1:0] MODE_UNKNOWN = 2'd3;
  // The drain time covers the longest request, which walks the whole table, plus the front end.
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 64;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } request_t;

  typedef struct packed {
    logic               present;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } outcome_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           mode_i = MODE_LOOKUP;
  logic [KEY_W-1:0]     key_bytes_i = '0;
  logic [LEN_W-1:0]     key_length_i = '0;
  logic                 done_o;
  logic                 was_present_o;
  logic [1:0]           status_o;
  logic [COUNT_W-1:0]   live_count_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = ADDR_TABLE_SIZE;
  logic [APB_DW-1:0]    pwdata = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  linear_probe_hash_set uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .key_bytes_i   (key_bytes_i),
    .key_length_i  (key_length_i),
    .done_o        (done_o),
    .was_present_o (was_present_o),
    .status_o      (status_o),
    .live_count_o  (live_count_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the table and its registers.
  bit [KEY_W-1:0]   tbl_key  [CAPACITY];
  bit [LEN_W-1:0]   tbl_len  [CAPACITY];
  bit               tbl_used [CAPACITY];
  bit               tbl_gone [CAPACITY];
  int unsigned      members = 0;
  logic [SIZE_W-1:0] size_reg = SIZE_RESET;

  request_t pending_requests[$];
  outcome_t expected_outcomes[$];
  logic [KEY_W-1:0] pool_keys[$];
  logic [LEN_W-1:0] pool_lens[$];
  int fail_count = 0;
  logic req_taken = 1'b0;
  int idle_left = 0;
  int burst_left = 0;

  function automatic outcome_t apply_request(request_t r);
    int unsigned n, len, sum, slot, i;
    logic [KEY_W-1:0] key;
    bit stopped, present;
    outcome_t o;
    n = size_reg;
    if (n < 2) n = 2;
    if (n > CAPACITY) n = CAPACITY;
    len = (r.len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : r.len;
    key = '0;
    sum = 0;
    for (i = 0; i < len; i++) begin
      key[8*i +: 8] = r.key[8*i +: 8];
      sum += int'(key[8*i +: 8]) * (i + 1);
    end
    slot = sum % n;
    stopped = 1'b0;
    for (i = 0; i < n; i++) begin
      if (!tbl_used[slot] || (tbl_len[slot] == len && tbl_key[slot] == key)) begin
        stopped = 1'b1;
        break;
      end
      slot = (slot + 1 >= n) ? 0 : slot + 1;
    end
    present = stopped && tbl_used[slot] && !tbl_gone[slot];
    o.status = STATUS_DONE;
    if (r.mode == MODE_INSERT) begin
      // Refusal at half occupancy wins even over a key that is already there.
      if (members >= n / 2) begin
        o.status = STATUS_REFUSED;
      end else if (!stopped) begin
        o.status = STATUS_NO_SLOT;
      end else if (!present) begin
        tbl_key[slot]  = key;
        tbl_len[slot]  = LEN_W'(len);
        tbl_used[slot] = 1'b1;
        tbl_gone[slot] = 1'b0;
        members++;
      end
    end else if (r.mode == MODE_REMOVE) begin
      if (present) begin
        tbl_gone[slot] = 1'b1;
        if (members > 0) members--;
      end
    end
    o.present = present;
    o.count = COUNT_W'(members);
    return o;
  endfunction

  function automatic request_t draw_request();
    request_t r;
    int k;
    int unsigned pick;
    logic [KEY_W-1:0] mask;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      r.key = {$urandom, $urandom};
      r.len = LEN_W'($urandom_range(0, 15));
    end else begin
      k = $urandom_range(0, pool_keys.size() - 1);
      r.len = pool_lens[k];
      mask = (r.len >= 8) ? '1 : (64'd1 << (8 * r.len)) - 64'd1;
      r.key = pool_keys[k] & mask;
      // The same key again, with junk in the bytes past its length.
      if ($urandom_range(0, 1)) r.key |= {$urandom, $urandom} & ~mask;
      if (r.len == 8 && $urandom_range(0, 3) == 0) r.len = LEN_W'($urandom_range(9, 15));
    end
    pick = $urandom_range(0, 19);
    r.mode = (pick < 8) ? MODE_INSERT : (pick < 13) ? MODE_REMOVE :
             (pick < 19) ? MODE_LOOKUP : MODE_UNKNOWN;
    return r;
  endfunction

  task automatic queue_req(input logic [1:0] mode, input logic [KEY_W-1:0] key,
                           input logic [LEN_W-1:0] len);
    pending_requests.push_back('{mode, key, len});
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || start || expected_outcomes.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic size_access(input bit wr, input logic [APB_DW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_TABLE_SIZE;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (wr) begin
      size_reg = value[SIZE_W-1:0];
    end else if (prdata !== APB_DW'(size_reg)) begin
      $error("table_size: expected %0d, got %0d", size_reg, prdata);
      fail_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(input logic [APB_DW-1:0] size_value, input int count,
                           input int pool_n);
    int k;
    wait_idle();
    size_access(1'b1, size_value);
    size_access(1'b0, '0);
    pool_keys.delete();
    pool_lens.delete();
    for (k = 0; k < pool_n; k++) begin
      pool_keys.push_back({$urandom, $urandom});
      pool_lens.push_back(LEN_W'($urandom_range(0, 8)));
    end
    for (k = 0; k < count; k++) pending_requests.push_back(draw_request());
  endtask

  // Request driver: bursts of back-to-back requests separated by random gaps.
  always @(negedge clk_i) begin
    request_t cur;
    if (rst_ni && (req_taken || !start)) begin
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        cur = pending_requests.pop_front();
        start        <= 1'b1;
        mode_i       <= cur.mode;
        key_bytes_i  <= cur.key;
        key_length_i <= cur.len;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          idle_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) :
                                                    $urandom_range(0, 3);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Accepted requests feed the predictor; each result strobe is checked in order.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_outcomes.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = expected_outcomes.pop_front();
          if (was_present_o !== want.present) begin
            $error("was_present: expected %0d, got %0d", want.present, was_present_o);
            fail_count++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            fail_count++;
          end
          if (live_count_o !== want.count) begin
            $error("live_count: expected %0d, got %0d", want.count, live_count_o);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        expected_outcomes.push_back(apply_request('{mode_i, key_bytes_i, key_length_i}));
      req_taken <= start && !busy;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    size_access(1'b0, '0);

    // Full-size table: empty key, widest key, long lengths, stray bytes, removal marks.
    queue_req(MODE_LOOKUP,  '1, 4'd0);
    queue_req(MODE_INSERT,  '0, 4'd0);
    queue_req(MODE_LOOKUP,  64'hDEAD_BEEF_0123_4567, 4'd0);
    queue_req(MODE_INSERT,  '1, 4'd8);
    queue_req(MODE_INSERT,  '1, 4'd15);
    queue_req(MODE_UNKNOWN, '1, 4'd8);
    queue_req(MODE_REMOVE,  '1, 4'd12);
    queue_req(MODE_LOOKUP,  '1, 4'd8);
    queue_req(MODE_REMOVE,  '1, 4'd8);
    queue_req(MODE_INSERT,  '1, 4'd8);
    queue_req(MODE_INSERT,  64'hFFFF_FFFF_FFFF_FF01, 4'd1);
    // Same home slot as the one-byte key above, so it probes past it.
    queue_req(MODE_INSERT,  64'h0001, 4'd2);
    queue_req(MODE_REMOVE,  64'h01, 4'd1);
    queue_req(MODE_LOOKUP,  64'h0001, 4'd2);
    queue_req(MODE_REMOVE,  '1, 4'd8);
    queue_req(MODE_REMOVE,  '0, 4'd0);
    queue_req(MODE_REMOVE,  64'h0001, 4'd2);

    // A size below the minimum, with old contents left in place: refusal and exhaustion.
    wait_idle();
    size_access(1'b1, 32'd0);
    size_access(1'b0, '0);
    queue_req(MODE_INSERT, 64'h01, 4'd1);
    queue_req(MODE_INSERT, 64'h02, 4'd1);
    queue_req(MODE_INSERT, 64'h01, 4'd1);
    queue_req(MODE_REMOVE, 64'h01, 4'd1);
    queue_req(MODE_INSERT, 64'h02, 4'd1);
    queue_req(MODE_LOOKUP, 64'h02, 4'd1);
    queue_req(MODE_REMOVE, 64'h02, 4'd1);
    queue_req(MODE_INSERT, 64'h03, 4'd1);

    run_phase(32'd1, 60, 4);
    run_phase(32'hFFFF_F803, 80, 5);
    run_phase(32'd7, 100, 10);
    run_phase(32'd16, 120, 16);
    run_phase(32'd64, 120, 40);
    run_phase(32'h0000_07FF, 120, 60);
    run_phase(32'd1025, 100, 60);
    run_phase(32'd1024, 100, 40);
    run_phase(32'd200, 100, 30);
    // Shrinking last strands members above the new size.
    run_phase(32'd5, 100, 8);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(100_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/lphs_pkg.sv
rtl/lphs_front.sv
rtl/lphs_queue.sv
rtl/lphs_back.sv
rtl/linear_probe_hash_set.sv
verif/linear_probe_hash_set_tb.sv
